[hw/rtl/slbm_pkg.sv]
// Shared types and constants for the serial loaded bank mapper.
// Used by every module of the block; depends on nothing.
package slbm_pkg;

  // request opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_REINIT = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_ROM_PRESENT = 4'd1;

  // internal mapper register selects (address bits 14:13)
  localparam logic [1:0] REG_CTRL = 2'd0;
  localparam logic [1:0] REG_CHR0 = 2'd1;
  localparam logic [1:0] REG_CHR1 = 2'd2;
  localparam logic [1:0] REG_PRG  = 2'd3;

  localparam logic [4:0] CTRL_RESET       = 5'h0C;
  localparam logic [7:0] PRG_COUNT_RESET  = 8'd16;
  localparam logic [7:0] PRG_COUNT_512K   = 8'd64;
  localparam logic [7:0] PRG_COUNT_1024K  = 8'd128;
  localparam logic [6:0] TOP_A_LARGE      = 7'd30;
  localparam logic [6:0] TOP_B_LARGE      = 7'd31;
  localparam logic [2:0] SHIFT_BITS       = 3'd5;

  typedef enum logic [1:0] {
    MODE_SMALL,
    MODE_512K,
    MODE_1024K
  } size_mode_t;

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
  } in_t;

  typedef struct packed {
    logic [6:0] prg_bank_a;
    logic [6:0] prg_bank_b;
    logic [6:0] prg_bank_c;
    logic [6:0] prg_bank_d;
    logic [1:0] mirroring;
    logic [5:0] chr_low_bank;
    logic [5:0] chr_high_bank;
    logic [2:0] shift_count;
  } out_t;

  // request held in the input register, handed to the mapping logic
  typedef struct packed {
    logic valid;
    logic fire;
    in_t  req;
  } step_t;

  function automatic size_mode_t mode_of(input logic [7:0] count);
    size_mode_t m;
    if (count == PRG_COUNT_1024K) m = MODE_1024K;
    else if (count == PRG_COUNT_512K) m = MODE_512K;
    else m = MODE_SMALL;
    return m;
  endfunction

endpackage

[hw/rtl/slbm_in_stage.sv]
// Input register of the bank mapper: holds one accepted request.
// Depends on slbm_pkg.
module slbm_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  slbm_pkg::in_t in_data,
  input  logic          advance,
  output slbm_pkg::step_t step
);

  logic          valid_r, valid_nxt;
  slbm_pkg::in_t req_r;

  // free slot, or the held request moves on this cycle
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) valid_nxt = 1'b1;
    else if (advance) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
  end

  assign step.valid = valid_r;
  assign step.fire  = advance;
  assign step.req   = req_r;

endmodule

[hw/rtl/slbm_map.sv]
// Mapper state and next-state logic: serial shift, register load, bank mapping.
// Depends on slbm_pkg; fed by slbm_in_stage, result registered in the top level.
module slbm_map (
  input  logic            clk,
  input  logic            rst_n,
  input  slbm_pkg::step_t step,
  input  logic [7:0]      prg_bank_count,
  input  logic            chr_rom_present,
  output slbm_pkg::out_t  map_nxt
);

  logic [4:0] shift_r, shift_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] prev_sel_r, prev_sel_nxt;
  logic [4:0] regs_r [4];
  logic [4:0] regs_nxt [4];
  logic [1:0] outer_r, outer_nxt;
  logic       swap_r, swap_nxt;
  logic [6:0] inner_r [4];
  logic [6:0] inner_nxt [4];
  logic [1:0] mirror_r, mirror_nxt;
  logic [5:0] chr_r [2];
  logic [5:0] chr_nxt [2];
  slbm_pkg::size_mode_t mode_r, mode_nxt;
  logic [6:0] top_a_r, top_a_nxt, top_b_r, top_b_nxt;

  slbm_pkg::size_mode_t cfg_mode;
  logic [6:0] cfg_top_a, cfg_top_b;
  logic [1:0] sel;
  logic [4:0] r0, m1, m2, m3;
  logic [6:0] bn;
  logic [2:0] cnt_inc;

  logic [1:0] final_outer;
  logic       final_swap;
  logic [5:0] final_chr [2];
  logic [1:0] final_mirror;
  logic [6:0] final_inner [4];

  // mode and top banks as a reinit would take them from the count register
  always_comb begin
    logic [7:0] less2, less1;
    less2 = prg_bank_count - 8'd2;
    less1 = prg_bank_count - 8'd1;
    cfg_mode = slbm_pkg::mode_of(prg_bank_count);
    if (cfg_mode == slbm_pkg::MODE_SMALL) begin
      cfg_top_a = less2[6:0];
      cfg_top_b = less1[6:0];
    end else begin
      cfg_top_a = slbm_pkg::TOP_A_LARGE;
      cfg_top_b = slbm_pkg::TOP_B_LARGE;
    end
  end

  assign sel = step.req.addr[14:13];
  assign r0  = regs_nxt[0];
  assign m1  = regs_nxt[1];
  assign m2  = regs_nxt[2];
  assign m3  = regs_nxt[3];
  assign bn  = {1'b0, m3, 1'b0};

  // next state for one request
  always_comb begin
    shift_nxt    = shift_r;
    cnt_nxt      = cnt_r;
    prev_sel_nxt = prev_sel_r;
    regs_nxt     = regs_r;
    outer_nxt    = outer_r;
    swap_nxt     = swap_r;
    inner_nxt    = inner_r;
    mirror_nxt   = mirror_r;
    chr_nxt      = chr_r;
    mode_nxt     = mode_r;
    top_a_nxt    = top_a_r;
    top_b_nxt    = top_b_r;
    cnt_inc      = 3'd0;

    if (step.req.op == slbm_pkg::OP_REINIT) begin
      shift_nxt = 5'd0;
      cnt_nxt   = 3'd0;
      regs_nxt  = '{slbm_pkg::CTRL_RESET, 5'd0, 5'd0, 5'd0};
      mode_nxt  = cfg_mode;
      outer_nxt = 2'd0;
      swap_nxt  = 1'b0;
      top_a_nxt = cfg_top_a;
      top_b_nxt = cfg_top_b;
      inner_nxt = '{7'd0, 7'd1, cfg_top_a, cfg_top_b};
    end else begin
      // a new register select restarts the serial load
      if (sel != prev_sel_r) begin
        shift_nxt = 5'd0;
        cnt_nxt   = 3'd0;
      end
      prev_sel_nxt = sel;
      if (step.req.data[7]) begin
        shift_nxt = 5'd0;
        cnt_nxt   = 3'd0;
      end else begin
        if (step.req.data[0]) shift_nxt = shift_nxt | (5'd1 << cnt_nxt);
        cnt_inc = cnt_nxt + 3'd1;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= slbm_pkg::SHIFT_BITS) begin
          regs_nxt[sel] = shift_nxt;
          shift_nxt     = 5'd0;
          cnt_nxt       = 3'd0;
        end
      end
    end
  end

  // register load side effects, using the freshly written register file
  always_comb begin
    logic loaded;
    logic [1:0] outer_v;
    logic       swap_v;
    logic [5:0] chr0_v, chr1_v;
    logic [1:0] mirror_v;
    logic [6:0] in0, in1, in2, in3;
    loaded   = (step.req.op == slbm_pkg::OP_WRITE) && !step.req.data[7] &&
               (cnt_inc >= slbm_pkg::SHIFT_BITS);
    outer_v  = outer_nxt;
    swap_v   = swap_nxt;
    chr0_v   = chr_nxt[0];
    chr1_v   = chr_nxt[1];
    mirror_v = mirror_nxt;
    in0 = inner_nxt[0];
    in1 = inner_nxt[1];
    in2 = inner_nxt[2];
    in3 = inner_nxt[3];
    if (loaded) begin
      case (sel)
        slbm_pkg::REG_CTRL: begin
          mirror_v = r0[1:0];
        end
        slbm_pkg::REG_CHR0: begin
          if (mode_r == slbm_pkg::MODE_1024K) begin
            if (r0[4]) begin
              // two-write swap handshake
              if (swap_r) begin
                outer_v = {r0[3] & m2[4], m1[4]};
                swap_v  = 1'b0;
              end else begin
                swap_v = 1'b1;
              end
            end else begin
              outer_v = m1[4] ? 2'd3 : 2'd0;
            end
          end else if (mode_r == slbm_pkg::MODE_512K && !chr_rom_present) begin
            outer_v = {1'b0, m1[4]};
          end else if (chr_rom_present) begin
            chr0_v = {1'b0, m1};
            if (!r0[4]) chr1_v = {1'b0, m1} + 6'd1;
          end else if (r0[4]) begin
            chr0_v = {1'b0, m1};
          end
        end
        slbm_pkg::REG_CHR1: begin
          if (mode_r == slbm_pkg::MODE_1024K && r0[3]) begin
            if (swap_r) begin
              outer_v = {m2[4], m1[4]};
              swap_v  = 1'b0;
            end else begin
              swap_v = 1'b1;
            end
          end
          if (r0[4]) chr1_v = {1'b0, m2};
        end
        slbm_pkg::REG_PRG: begin
          if (r0[3]) begin
            if (r0[2]) begin
              in0 = bn;
              in1 = bn + 7'd1;
              in2 = top_a_r;
              in3 = top_b_r;
            end else if (mode_r == slbm_pkg::MODE_SMALL) begin
              in0 = 7'd0;
              in1 = 7'd1;
              in2 = bn;
              in3 = bn + 7'd1;
            end
          end else begin
            in0 = bn;
            in1 = bn + 7'd1;
            if (mode_r == slbm_pkg::MODE_SMALL) begin
              in2 = bn + 7'd2;
              in3 = bn + 7'd3;
            end
          end
        end
        default: begin
          mirror_v = mirror_nxt;
        end
      endcase
    end
    final_outer  = outer_v;
    final_swap   = swap_v;
    final_chr[0] = chr0_v;
    final_chr[1] = chr1_v;
    final_mirror = mirror_v;
    final_inner  = '{in0, in1, in2, in3};
  end

  // state registers, advanced once per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r    <= 5'd0;
      cnt_r      <= 3'd0;
      prev_sel_r <= 2'd0;
      regs_r     <= '{slbm_pkg::CTRL_RESET, 5'd0, 5'd0, 5'd0};
      outer_r    <= 2'd0;
      swap_r     <= 1'b0;
      inner_r    <= '{7'd0, 7'd1, 7'd14, 7'd15};
      mirror_r   <= 2'd0;
      chr_r      <= '{6'd0, 6'd0};
      mode_r     <= slbm_pkg::MODE_SMALL;
      top_a_r    <= 7'd14;
      top_b_r    <= 7'd15;
    end else if (step.fire) begin
      shift_r    <= shift_nxt;
      cnt_r      <= cnt_nxt;
      prev_sel_r <= prev_sel_nxt;
      regs_r     <= regs_nxt;
      outer_r    <= final_outer;
      swap_r     <= final_swap;
      inner_r    <= final_inner;
      mirror_r   <= final_mirror;
      chr_r      <= final_chr;
      mode_r     <= mode_nxt;
      top_a_r    <= top_a_nxt;
      top_b_r    <= top_b_nxt;
    end
  end

  // mapping seen after this request
  assign map_nxt.prg_bank_a    = {final_outer, final_inner[0][4:0]};
  assign map_nxt.prg_bank_b    = {final_outer, final_inner[1][4:0]};
  assign map_nxt.prg_bank_c    = {final_outer, final_inner[2][4:0]};
  assign map_nxt.prg_bank_d    = {final_outer, final_inner[3][4:0]};
  assign map_nxt.mirroring     = final_mirror;
  assign map_nxt.chr_low_bank  = final_chr[0];
  assign map_nxt.chr_high_bank = final_chr[1];
  assign map_nxt.shift_count   = cnt_nxt;

endmodule

[hw/rtl/serial_loaded_bank_mapper_core.sv]
// Top level of the serial loaded bank mapper: config registers, result register.
// Depends on slbm_pkg, slbm_in_stage and slbm_map.
//
//  channel | signals                         | dir | payload
//  --------+---------------------------------+-----+--------------------------
//  in      | in_valid / in_ready / in_data   | in  | op, addr, data
//  out     | out_valid / out_ready / out_data| out | four prg banks, mirroring,
//          |                                 |     | two chr banks, shift_count
//  cfg     | cfg_valid / cfg_ready           | in  | cfg_index, cfg_data
//
// One request per cycle unless the result stalls; a request waits in the input
// register, which feeds the mapping logic into the result register.
// Synchronous active-low reset puts the mapper in its reinitialized state with a
// bank count of 16 and character ROM present. No clearing pass is needed.
// A stalled result holds both stages; the input register frees as soon as the
// result register can take the next mapping. cfg is always ready.
module serial_loaded_bank_mapper_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  slbm_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output slbm_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [slbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data
);

  logic            advance;
  slbm_pkg::step_t step;
  slbm_pkg::out_t  map_nxt;
  slbm_pkg::out_t  out_r;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      prg_count_r;
  logic            chr_present_r;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_count_r   <= slbm_pkg::PRG_COUNT_RESET;
      chr_present_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == slbm_pkg::CFG_PRG_BANK_COUNT) prg_count_r <= cfg_data;
      if (cfg_index == slbm_pkg::CFG_CHR_ROM_PRESENT) chr_present_r <= cfg_data[0];
    end
  end

  // request moves into the result register
  assign advance = step.valid && (!out_valid_r || out_ready);

  slbm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .step     (step)
  );

  slbm_map u_map (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .prg_bank_count  (prg_count_r),
    .chr_rom_present (chr_present_r),
    .map_nxt         (map_nxt)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= map_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // serial count never reaches a full register
  a_shift_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.shift_count < slbm_pkg::SHIFT_BITS))
    else $error("shift count out of range");

  // reinit leaves an empty shift and the first two banks at 0 and 1
  a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && step.req.op == slbm_pkg::OP_REINIT) |=>
      (out_valid_r && out_r.shift_count == 3'd0 &&
       out_r.prg_bank_a == 7'd0 && out_r.prg_bank_b == 7'd1))
    else $error("reinit mapping wrong");

  // a result is only produced from a held request
  a_advance_src: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && $past(!out_valid_r) && !$past(step.valid)) |-> !out_valid_nxt ||
      advance)
    else $error("result without request");

endmodule

[test/tb_serial_loaded_bank_mapper_core.sv]
// Self-checking testbench for serial_loaded_bank_mapper_core: a scoreboard class
// predicts the bank mapping for every accepted request and checks each result.
// Depends on slbm_pkg and the serial_loaded_bank_mapper_core RTL only.

// Mapping predictor plus the queue of mappings still owed by the block.
class mapping_scoreboard;
  bit [7:0] prg_count;
  bit       chr_rom;

  bit [4:0] shift_reg;
  bit [2:0] bit_cnt;
  bit [1:0] last_sel;
  bit [4:0] regs [4];
  bit [1:0] outer;
  bit       swap_armed;
  bit [6:0] inner [4];
  bit [1:0] mirror;
  bit [5:0] chr [2];
  slbm_pkg::size_mode_t mode;
  bit [6:0] top_lo;
  bit [6:0] top_hi;

  slbm_pkg::out_t expected_maps[$];
  int err_count;

  function new();
    prg_count = slbm_pkg::PRG_COUNT_RESET;
    chr_rom   = 1'b1;
    last_sel  = 2'd0;
    mirror    = 2'd0;
    chr[0]    = 6'd0;
    chr[1]    = 6'd0;
    err_count = 0;
    reload();
  endfunction

  function int pending();
    return expected_maps.size();
  endfunction

  // config write; bank count only latches at the next reload
  function void set_reg(bit [3:0] idx, bit [7:0] val);
    if (idx == slbm_pkg::CFG_PRG_BANK_COUNT) prg_count = val;
    else if (idx == slbm_pkg::CFG_CHR_ROM_PRESENT) chr_rom = val[0];
  endfunction

  // reinit: control back to reset value, mode and top banks relatched
  function void reload();
    bit [7:0] t;
    shift_reg = 5'd0;
    bit_cnt   = 3'd0;
    regs[0]   = slbm_pkg::CTRL_RESET;
    regs[1]   = 5'd0;
    regs[2]   = 5'd0;
    regs[3]   = 5'd0;
    if (prg_count == slbm_pkg::PRG_COUNT_1024K) mode = slbm_pkg::MODE_1024K;
    else if (prg_count == slbm_pkg::PRG_COUNT_512K) mode = slbm_pkg::MODE_512K;
    else mode = slbm_pkg::MODE_SMALL;
    outer      = 2'd0;
    swap_armed = 1'b0;
    if (mode == slbm_pkg::MODE_SMALL) begin
      t      = prg_count - 8'd2;
      top_lo = t[6:0];
      t      = prg_count - 8'd1;
      top_hi = t[6:0];
    end else begin
      top_lo = slbm_pkg::TOP_A_LARGE;
      top_hi = slbm_pkg::TOP_B_LARGE;
    end
    inner[0] = 7'd0;
    inner[1] = 7'd1;
    inner[2] = top_lo;
    inner[3] = top_hi;
  endfunction

  // two-write outer base swap used in 1024K mode
  function void swap_step(bit use_hi);
    if (swap_armed) begin
      outer = {1'b0, regs[1][4]};
      if (use_hi) outer[1] = regs[2][4];
      swap_armed = 1'b0;
    end else begin
      swap_armed = 1'b1;
    end
  endfunction

  // side effects of a completed 5-bit load
  function void load_reg(bit [1:0] sel);
    bit [4:0] r0;
    bit [6:0] bn;
    r0 = regs[0];
    bn = {1'b0, regs[3], 1'b0};
    case (sel)
      slbm_pkg::REG_CTRL: mirror = r0[1:0];
      slbm_pkg::REG_CHR0: begin
        if (mode == slbm_pkg::MODE_1024K) begin
          if (r0[4]) swap_step(r0[3]);
          else outer = regs[1][4] ? 2'd3 : 2'd0;
        end else if (mode == slbm_pkg::MODE_512K && !chr_rom) begin
          outer = {1'b0, regs[1][4]};
        end else if (chr_rom) begin
          chr[0] = {1'b0, regs[1]};
          if (!r0[4]) chr[1] = {1'b0, regs[1]} + 6'd1;
        end else if (r0[4]) begin
          chr[0] = {1'b0, regs[1]};
        end
      end
      slbm_pkg::REG_CHR1: begin
        if (mode == slbm_pkg::MODE_1024K && r0[3]) swap_step(1'b1);
        if (r0[4]) chr[1] = {1'b0, regs[2]};
      end
      default: begin
        if (r0[3]) begin
          if (r0[2]) begin
            inner[0] = bn;
            inner[1] = bn + 7'd1;
            inner[2] = top_lo;
            inner[3] = top_hi;
          end else if (mode == slbm_pkg::MODE_SMALL) begin
            inner[0] = 7'd0;
            inner[1] = 7'd1;
            inner[2] = bn;
            inner[3] = bn + 7'd1;
          end
        end else begin
          inner[0] = bn;
          inner[1] = bn + 7'd1;
          if (mode == slbm_pkg::MODE_SMALL) begin
            inner[2] = bn + 7'd2;
            inner[3] = bn + 7'd3;
          end
        end
      end
    endcase
  endfunction

  // advance the predictor by one accepted request, queue the mapping it yields
  function void note_request(slbm_pkg::in_t req);
    bit [1:0] sel;
    slbm_pkg::out_t m;
    if (req.op == slbm_pkg::OP_REINIT) begin
      reload();
    end else begin
      sel = req.addr[14:13];
      if (sel != last_sel) begin
        shift_reg = 5'd0;
        bit_cnt   = 3'd0;
      end
      last_sel = sel;
      if (req.data[7]) begin
        shift_reg = 5'd0;
        bit_cnt   = 3'd0;
      end else begin
        if (req.data[0]) shift_reg[bit_cnt] = 1'b1;
        bit_cnt = bit_cnt + 3'd1;
        if (bit_cnt >= slbm_pkg::SHIFT_BITS) begin
          regs[sel] = shift_reg;
          shift_reg = 5'd0;
          bit_cnt   = 3'd0;
          load_reg(sel);
        end
      end
    end
    m.prg_bank_a    = {outer, inner[0][4:0]};
    m.prg_bank_b    = {outer, inner[1][4:0]};
    m.prg_bank_c    = {outer, inner[2][4:0]};
    m.prg_bank_d    = {outer, inner[3][4:0]};
    m.mirroring     = mirror;
    m.chr_low_bank  = chr[0];
    m.chr_high_bank = chr[1];
    m.shift_count   = bit_cnt;
    expected_maps.push_back(m);
  endfunction

  task report_mismatch(string what);
    err_count++;
    $display("mismatch: %s", what);
  endtask

  task field_check(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // compare one result with the oldest outstanding mapping
  task check_mapping(slbm_pkg::out_t got);
    slbm_pkg::out_t want;
    if (expected_maps.size() == 0) begin
      report_mismatch("result with no request outstanding");
    end else begin
      want = expected_maps.pop_front();
      field_check("prg_bank_a", got.prg_bank_a, want.prg_bank_a);
      field_check("prg_bank_b", got.prg_bank_b, want.prg_bank_b);
      field_check("prg_bank_c", got.prg_bank_c, want.prg_bank_c);
      field_check("prg_bank_d", got.prg_bank_d, want.prg_bank_d);
      field_check("mirroring", got.mirroring, want.mirroring);
      field_check("chr_low_bank", got.chr_low_bank, want.chr_low_bank);
      field_check("chr_high_bank", got.chr_high_bank, want.chr_high_bank);
      field_check("shift_count", got.shift_count, want.shift_count);
    end
  endtask
endclass

module tb_serial_loaded_bank_mapper_core;
  timeunit 1ns;
  timeprecision 1ps;

  // index with no register behind it
  localparam logic [slbm_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd14;
  localparam int PHASES = 9;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  slbm_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  slbm_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [slbm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;

  mapping_scoreboard sb;
  bit tx_gaps;
  bit rx_gaps;

  logic [7:0] phase_count [PHASES] = '{8'd128, 8'd128, 8'd64, 8'd64, 8'd2, 8'd0,
                                       8'd255, 8'd1, 8'd16};
  bit phase_chr   [PHASES] = '{1, 0, 0, 1, 1, 0, 1, 0, 1};

  serial_loaded_bank_mapper_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic slbm_pkg::in_t make_req(logic op, logic [15:0] addr,
                                             logic [7:0] data);
    slbm_pkg::in_t r;
    r.op   = op;
    r.addr = addr;
    r.data = data;
    return r;
  endfunction

  // CPU write to register sel; unused address bits random
  function automatic slbm_pkg::in_t make_write(logic [1:0] sel, logic [7:0] data);
    logic [15:0] a;
    a = 16'($urandom);
    a[14:13] = sel;
    return make_req(slbm_pkg::OP_WRITE, a, data);
  endfunction

  // send one request, optionally after an idle gap; valid stays high after accept
  task automatic send_req(slbm_pkg::in_t r);
    int gap;
    if ($urandom_range(0, 29) == 0) tx_gaps = !tx_gaps;
    gap = tx_gaps ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
  endtask

  // five serial writes that load val into register sel
  task automatic load_serial(logic [1:0] sel, logic [4:0] val);
    logic [7:0] d;
    for (int j = 0; j < 5; j++) begin
      d = 8'($urandom);
      d[7] = 1'b0;
      d[0] = val[j];
      send_req(make_write(sel, d));
    end
  endtask

  // let every outstanding mapping come back before touching config
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [slbm_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    repeat ($urandom_range(1, 4)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // mostly complete 5-bit loads, plus clears, reinits, cut-short loads and noise
  task automatic random_traffic(int n);
    int k;
    int pick;
    int len;
    logic [1:0] sel;
    logic [7:0] d;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(0, 99);
      sel  = 2'($urandom);
      if (pick < 65) begin
        load_serial(sel, 5'($urandom));
        k += 5;
      end else if (pick < 75) begin
        d = 8'($urandom);
        d[7] = 1'b1;
        send_req(make_write(sel, d));
        k++;
      end else if (pick < 80) begin
        send_req(make_req(slbm_pkg::OP_REINIT, 16'($urandom), 8'($urandom)));
        k++;
      end else if (pick < 92) begin
        len = $urandom_range(1, 4);
        for (int j = 0; j < len; j++) begin
          d = 8'($urandom);
          d[7] = 1'b0;
          send_req(make_write(sel, d));
        end
        k += len;
      end else begin
        send_req(make_req(1'($urandom), 16'($urandom), 8'($urandom)));
        k++;
      end
    end
  endtask

  // result side: random stalls, check every accepted mapping
  initial begin
    rx_gaps = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      int stall;
      if ($urandom_range(0, 29) == 0) rx_gaps = !rx_gaps;
      stall = rx_gaps ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_mapping(out_data);
    end
  end

  // stimulus and end of run
  initial begin
    sb        = new();
    tx_gaps   = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reinit, shift clear, each register, select change, extremes
    send_req(make_req(slbm_pkg::OP_REINIT, 16'hFFFF, 8'hFF));
    send_req(make_req(slbm_pkg::OP_WRITE, 16'h8000, 8'h80));
    load_serial(slbm_pkg::REG_CTRL, 5'h1F);
    load_serial(slbm_pkg::REG_PRG, 5'h1F);
    send_req(make_write(slbm_pkg::REG_CHR0, 8'h01));
    send_req(make_write(slbm_pkg::REG_CHR0, 8'h01));
    load_serial(slbm_pkg::REG_CHR1, 5'h15);
    send_req(make_req(slbm_pkg::OP_WRITE, 16'hFFFF, 8'hFF));
    load_serial(slbm_pkg::REG_CHR0, 5'h1F);
    send_req(make_req(slbm_pkg::OP_WRITE, 16'h0000, 8'h7E));
    send_req(make_req(slbm_pkg::OP_REINIT, 16'h0000, 8'h00));

    // config phases: each bank count mode, both character memory types
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(slbm_pkg::CFG_PRG_BANK_COUNT, phase_count[p]);
      write_reg(slbm_pkg::CFG_CHR_ROM_PRESENT, {7'($urandom), phase_chr[p]});
      if (p == 0) write_reg(CFG_IDX_SPARE, 8'($urandom));
      // a few writes under the old bank count before it latches
      random_traffic($urandom_range(0, 3));
      send_req(make_req(slbm_pkg::OP_REINIT, 16'($urandom), 8'($urandom)));
      random_traffic(70);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
